// ----- sv/hsd_pkg.sv -----
`default_nettype none

package hsd_pkg;

  localparam int unsigned DataW = 32;

  // One item on the load side
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last_in;
  } in_item_t;

  // One item of the sorted run
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/heap_sort_descending_unit.sv -----
// Descending heap sorter. Items are loaded one per cycle while in_stall_o is low.
// Up to MAX_ITEMS items are kept, and any item beyond that is dropped. The item
// with last_in set starts the sort. The buffer is turned into a min-heap
// bottom-up, and then the root is repeatedly moved to the end of the shrinking
// heap. The run then comes out largest first. The final item of the run has
// last_out set, and overflow is set on every item of a run that lost items.
// Every step of the sort goes through one buffer memory. It has two synchronous
// read ports and one write port. A sift visits each heap level in StStep, which
// reads both children, and then in StCmp, which compares and writes back. Moving
// the root to the end goes through StNext, which reads the root and the tail,
// and StSwap. An emitted item is read from the buffer and then registered.
// While the sort and the emit are running, in_stall_o is high. The next load can
// begin while the final result still sits in the output register.
`default_nettype none

module heap_sort_descending_unit import hsd_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned KW = AW + 1;

  localparam logic [2:0] StLoad  = 3'd0;
  localparam logic [2:0] StFetch = 3'd1;
  localparam logic [2:0] StStep  = 3'd2;
  localparam logic [2:0] StCmp   = 3'd3;
  localparam logic [2:0] StNext  = 3'd4;
  localparam logic [2:0] StSwap  = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  // Buffer memory
  logic signed [DataW-1:0] mem [MAX_ITEMS];

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic                    drop_q, drop_d;
  logic [CW-1:0]           len_q, len_d;
  logic [AW-1:0]           node_q, node_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [AW-1:0]           end_q, end_d;
  logic                    build_q, build_d;
  logic [AW-1:0]           k_q, k_d;
  logic                    pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q, out_item_d;
  logic signed [DataW-1:0] x_q, x_d;
  logic signed [DataW-1:0] ra_q, rb_q;

  logic                    rd_a_en, rd_b_en, wr_en;
  logic [AW-1:0]           rd_a_addr, rd_b_addr, wr_addr;
  logic signed [DataW-1:0] wr_data;

  logic [KW-1:0]           kid_l, kid_r, len_k;
  logic                    has_r, pick_right;
  logic signed [DataW-1:0] pick_val;
  logic [AW-1:0]           pick_addr;
  logic                    full;
  logic [CW-1:0]           n_load, half;
  logic                    in_acc, out_free, emit_last;

  // Child addresses and the smaller child
  assign kid_l      = {node_q, 1'b1};
  assign kid_r      = kid_l + KW'(1);
  assign len_k      = KW'(len_q);
  assign has_r      = kid_r < len_k;
  assign pick_right = has_r && !(ra_q < rb_q);
  assign pick_val   = pick_right ? rb_q : ra_q;
  assign pick_addr  = pick_right ? kid_r[AW-1:0] : kid_l[AW-1:0];

  assign full      = count_q == CW'(MAX_ITEMS);
  assign n_load    = full ? count_q : count_q + CW'(1);
  assign half      = n_load >> 1;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_last = k_q == AW'(count_q - CW'(1));

  assign in_stall_o  = state_q != StLoad;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Sequence load, heap build, extraction and emit
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    len_d       = len_q;
    node_d      = node_q;
    idx_d       = idx_q;
    end_d       = end_q;
    build_d     = build_q;
    k_d         = k_q;
    pend_d      = pend_q;
    x_d         = x_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    rd_a_en     = 1'b0;
    rd_a_addr   = '0;
    rd_b_en     = 1'b0;
    rd_b_addr   = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_addr = count_q[AW-1:0];
            wr_data = in_item_i.value;
          end
          count_d = n_load;
          if (in_item_i.last_in) begin
            len_d = n_load;
            k_d   = '0;
            if (n_load < CW'(2)) begin
              state_d = StEmit;
            end else begin
              build_d   = 1'b1;
              idx_d     = AW'(half - CW'(1));
              node_d    = AW'(half - CW'(1));
              rd_a_en   = 1'b1;
              rd_a_addr = AW'(half - CW'(1));
              state_d   = StFetch;
            end
          end
        end
      end
      StFetch: begin
        x_d     = ra_q;
        state_d = StStep;
      end
      StStep: begin
        if (kid_l < len_k) begin
          rd_a_en   = 1'b1;
          rd_a_addr = kid_l[AW-1:0];
          rd_b_en   = 1'b1;
          rd_b_addr = kid_r[AW-1:0];
          state_d   = StCmp;
        end else begin
          wr_en   = 1'b1;
          wr_addr = node_q;
          wr_data = x_q;
          state_d = StNext;
        end
      end
      StCmp: begin
        wr_en   = 1'b1;
        wr_addr = node_q;
        if (x_q > pick_val) begin
          wr_data = pick_val;
          node_d  = pick_addr;
          state_d = StStep;
        end else begin
          wr_data = x_q;
          state_d = StNext;
        end
      end
      StNext: begin
        if (build_q) begin
          if (idx_q == '0) begin
            build_d = 1'b0;
            end_d   = AW'(len_q - CW'(1));
          end else begin
            idx_d     = idx_q - AW'(1);
            node_d    = idx_q - AW'(1);
            rd_a_en   = 1'b1;
            rd_a_addr = idx_q - AW'(1);
            state_d   = StFetch;
          end
        end else if (end_q == '0) begin
          state_d = StEmit;
        end else begin
          rd_a_en   = 1'b1;
          rd_a_addr = '0;
          rd_b_en   = 1'b1;
          rd_b_addr = end_q;
          state_d   = StSwap;
        end
      end
      StSwap: begin
        // Move the root to the end and sift the old tail from the root
        wr_en   = 1'b1;
        wr_addr = end_q;
        wr_data = ra_q;
        x_d     = rb_q;
        node_d  = '0;
        len_d   = CW'(end_q);
        end_d   = end_q - AW'(1);
        state_d = StStep;
      end
      StEmit: begin
        if (pend_q) begin
          pend_d      = 1'b0;
          out_valid_d = 1'b1;
          out_item_d  = '{sorted_value: ra_q, last_out: emit_last, overflow: drop_q};
          if (emit_last) begin
            count_d = '0;
            drop_d  = 1'b0;
            k_d     = '0;
            state_d = StLoad;
          end else begin
            k_d = k_q + AW'(1);
          end
        end else if (out_free) begin
          rd_a_en   = 1'b1;
          rd_a_addr = k_q;
          pend_d    = 1'b1;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      drop_q      <= 1'b0;
      len_q       <= '0;
      node_q      <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      build_q     <= 1'b0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      len_q       <= len_d;
      node_q      <= node_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      build_q     <= build_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    out_item_q <= out_item_d;
  end

  // Buffer memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      ra_q <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rb_q <= mem[rd_b_addr];
    end
  end

  // Never count past capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("item count exceeds capacity");

  // A read for output finds the output register free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("output register overwritten");

  // A sift step stays inside the heap
  a_node_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStep || state_q == StCmp) |-> CW'(node_q) < len_q)
    else $error("sift node outside heap");

  // The last item of a set stops the load
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.last_in) |=> in_stall_o)
    else $error("sort did not start");

endmodule

`default_nettype wire

// ----- verif/tb_heap_sort_descending_unit.sv -----
`timescale 1ns / 1ps

module tb_heap_sort_descending_unit;
  import hsd_pkg::*;

  localparam int Capacity = 64;
  localparam int RandomItems = 280;
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 100;

  // One row of the directed stimulus; exp_value is used only when fixed_exp is set
  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        fixed_exp;
    logic [31:0] exp_value;
  } dir_row_t;

  localparam int DirRows = 22;
  localparam dir_row_t DirTable [DirRows] = '{
    // single-item sets at the extremes
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // extremes mixed in one set
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    // equal values
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b1, 1'b0, 32'h0},
    // two items, both orders
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
    // negative run arriving already descending
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFC, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFB, 1'b1, 1'b0, 32'h0},
    // alternating bit patterns
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b1, 1'b0, 32'h0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Sorter model state
  logic signed [31:0] held_vals [Capacity];
  int                 held_count = 0;
  bit                 lost_any = 1'b0;
  out_item_t          sorted_due [$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  heap_sort_descending_unit #(
    .MAX_ITEMS(Capacity)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Load one item; on the last mark rank the held values largest first
  function automatic void load_and_rank(input in_item_t it, input bit emit);
    logic signed [31:0] ranked [Capacity];
    logic signed [31:0] v;
    int                 j;
    out_item_t          res;
    if (held_count < Capacity) begin
      held_vals[held_count] = it.value;
      held_count++;
    end else begin
      lost_any = 1'b1;
    end
    if (!it.last_in) return;
    for (int i = 0; i < held_count; i++) begin
      v = held_vals[i];
      j = i;
      while (j > 0 && ranked[j-1] < v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    for (int k = 0; k < held_count; k++) begin
      res.sorted_value = ranked[k];
      res.last_out     = (k == held_count - 1);
      res.overflow     = lost_any;
      if (emit) sorted_due.push_back(res);
    end
    held_count = 0;
    lost_any   = 1'b0;
  endfunction

  // Present one item, hold it until taken, then idle per the burst pattern
  task automatic send_item(input in_item_t it, input bit fixed_exp, input out_item_t fixed_res);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    load_and_rank(it, !fixed_exp);
    if (fixed_exp) sorted_due.push_back(fixed_res);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 6)) - 32'd3;
      1: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      3: return 32'h8000_0000 + 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Send one set of n items, the final one marked last
  task automatic send_set(input int n);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      it.value   = pick_value();
      it.last_in = (k == n - 1);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Stall the result side in phases: none, light, heavy
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(30, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  function automatic void field_diff(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      error_count++;
    end
  endfunction

  // Check each taken result against the oldest one due
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0h last %0b ovf %0b",
                 $time, out_item.sorted_value, out_item.last_out, out_item.overflow);
        error_count++;
      end else begin
        want = sorted_due.pop_front();
        field_diff("sorted_value", want.sorted_value, out_item.sorted_value);
        field_diff("last_out", 32'(want.last_out), 32'(out_item.last_out));
        field_diff("overflow", 32'(want.overflow), 32'(out_item.overflow));
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t  it;
    out_item_t fixed_res;
    int        random_sent;
    int        set_len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < DirRows; r++) begin
      it.value               = DirTable[r].value;
      it.last_in             = DirTable[r].last;
      fixed_res.sorted_value = DirTable[r].exp_value;
      fixed_res.last_out     = 1'b1;
      fixed_res.overflow     = 1'b0;
      send_item(it, DirTable[r].fixed_exp, fixed_res);
    end

    // Fill exactly, then overfill so the marked item itself is dropped
    send_set(Capacity);
    send_set(Capacity + 1);
    random_sent = DirRows + 2 * Capacity + 1;

    // Random sets, mostly small, a few full or overflowing
    while (random_sent < RandomItems) begin
      case ($urandom_range(0, 19))
        0: set_len = Capacity + $urandom_range(1, 4);
        1, 2: set_len = $urandom_range(40, Capacity);
        3, 4, 5, 6, 7: set_len = $urandom_range(9, 30);
        default: set_len = $urandom_range(1, 8);
      endcase
      send_set(set_len);
      random_sent += set_len;
    end
    in_valid <= 1'b0;

    // Drain the sorted runs, then give the block time to show stray results
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sorted_due.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/hsd_pkg.sv
sv/heap_sort_descending_unit.sv
verif/tb_heap_sort_descending_unit.sv
